/* hdl/tpv_pkg.sv */
`timescale 1ns / 1ps
// tpv_pkg: types, constants and byte class helpers for the temperature packet validator
// no dependencies

package tpv_pkg;

    localparam int unsigned MAX_INT_DIGITS = 5;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned MAG_W   = 20;
    localparam int unsigned SUM_W   = 12;
    localparam int unsigned RECV_W  = 16;
    localparam int unsigned TEMP_W  = 21;

    localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;

    localparam logic [MAG_W-1:0]  MAG_MAX  = 20'd999999;
    localparam logic [RECV_W-1:0] RECV_MAX = 16'hFFFF;
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_MINUS   = 4'd1,
        PH_INT     = 4'd2,
        PH_DOT     = 4'd3,
        PH_FRAC    = 4'd4,
        PH_TBAD    = 4'd5,
        PH_CEMPTY  = 4'd6,
        PH_CWS     = 4'd7,
        PH_CSIGN   = 4'd8,
        PH_CDIGITS = 4'd9,
        PH_CDONE   = 4'd10,
        PH_CBAD    = 4'd11
    } phase_t;

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

endpackage

/* hdl/temperature_packet_validator.sv */
`timescale 1ns / 1ps
// temperature_packet_validator: byte-serial parser and checker for "[-]d.d;checksum" packets
// depends on tpv_pkg
//
// usage:
//   input channel: byte_in and end_of_packet with in_valid / in_ready, one byte per item
//   output channel: packet_valid, temp_written, temp_tenths with out_valid / out_ready
//   one result item is given for each byte marked end_of_packet, none for other bytes
//   throughput: one byte per cycle unless stalled; bytes are registered, then one
//   pass of logic (a multiply by ten with saturation and a few compares) updates
//   the packet state; a final byte's result is then registered and raises out_valid
//   stall: a held result blocks only the next final byte; other bytes keep flowing,
//   and in_ready drops only when a final byte waits for a free result register
//   reset: all packet state returns to the start of the temperature field and both
//   valid flags clear; after each final byte the packet state returns there as well

module temperature_packet_validator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tpv_pkg::BYTE_W-1:0]        byte_in,
    input  logic                              end_of_packet,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              packet_valid,
    output logic                              temp_written,
    output logic signed [tpv_pkg::TEMP_W-1:0] temp_tenths
);

    import tpv_pkg::*;

    logic               st_valid_reg;
    logic [BYTE_W-1:0]  st_byte_reg;
    logic               st_eop_reg;

    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [RECV_W-1:0]  recv_reg, recv_next;
    logic               rneg_reg, rneg_next;
    logic               rovf_reg, rovf_next;
    logic               fe_reg, fe_next;

    logic               out_valid_reg;
    logic               pv_reg;
    logic               tw_reg;
    logic [TEMP_W-1:0]  tt_reg;

    logic               pv_c;
    logic               tw_c;
    logic [TEMP_W-1:0]  tt_c;

    logic               out_free;
    logic               st_fire;

    logic [3:0]         digit;
    logic [CNT_W-1:0]   cnt_inc;
    logic               int_too_long;
    logic [23:0]        mag_ext;
    logic [MAG_W-1:0]   mag_dig;
    logic [19:0]        recv_ext;
    logic [RECV_W-1:0]  recv_dig;
    logic               recv_sat;

    assign out_free = !out_valid_reg || out_ready;
    assign st_fire  = st_valid_reg && (!st_eop_reg || out_free);
    assign in_ready = !st_valid_reg || st_fire;

    // digit arithmetic
    assign digit        = st_byte_reg[3:0];
    assign cnt_inc      = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign int_too_long = cnt_inc > CNT_W'(MAX_INT_DIGITS);
    assign mag_ext      = ({4'd0, mag_reg} << 3) + ({4'd0, mag_reg} << 1) + {20'd0, digit};
    assign mag_dig      = (mag_ext > {4'd0, MAG_MAX}) ? MAG_MAX : mag_ext[MAG_W-1:0];
    assign recv_ext     = ({4'd0, recv_reg} << 3) + ({4'd0, recv_reg} << 1) + {16'd0, digit};
    assign recv_sat     = recv_ext > {4'd0, RECV_MAX};
    assign recv_dig     = recv_sat ? RECV_MAX : recv_ext[RECV_W-1:0];

    always_comb
    begin : next_state
        phase_next = phase_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        sum_next   = sum_reg;
        recv_next  = recv_reg;
        rneg_next  = rneg_reg;
        rovf_next  = rovf_reg;
        fe_next    = fe_reg;
        if (phase_reg < PH_CEMPTY)
        begin
            if (st_byte_reg == CHAR_SEMI)
            begin
                if (phase_reg != PH_FRAC)
                begin
                    fe_next = 1'b1;
                end
                phase_next = PH_CEMPTY;
            end
            else
            begin
                sum_next = sum_reg + {4'd0, st_byte_reg};
                case (phase_reg)
                    PH_START, PH_MINUS, PH_INT:
                    begin
                        if (phase_reg == PH_START && st_byte_reg == CHAR_MINUS)
                        begin
                            neg_next   = 1'b1;
                            phase_next = PH_MINUS;
                        end
                        else if (phase_reg == PH_INT && st_byte_reg == CHAR_DOT)
                        begin
                            phase_next = PH_DOT;
                        end
                        else if (is_digit(st_byte_reg))
                        begin
                            cnt_next = cnt_inc;
                            if (int_too_long)
                            begin
                                fe_next    = 1'b1;
                                phase_next = PH_TBAD;
                            end
                            else
                            begin
                                mag_next   = mag_dig;
                                phase_next = PH_INT;
                            end
                        end
                        else
                        begin
                            fe_next    = 1'b1;
                            phase_next = PH_TBAD;
                        end
                    end
                    PH_DOT:
                    begin
                        if (is_digit(st_byte_reg))
                        begin
                            mag_next   = mag_dig;
                            phase_next = PH_FRAC;
                        end
                        else
                        begin
                            fe_next    = 1'b1;
                            phase_next = PH_TBAD;
                        end
                    end
                    default:
                    begin
                        fe_next    = 1'b1;
                        phase_next = PH_TBAD;
                    end
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PH_CEMPTY, PH_CWS:
                begin
                    if (is_space(st_byte_reg))
                    begin
                        phase_next = PH_CWS;
                    end
                    else if (st_byte_reg == CHAR_PLUS)
                    begin
                        phase_next = PH_CSIGN;
                    end
                    else if (st_byte_reg == CHAR_MINUS)
                    begin
                        rneg_next  = 1'b1;
                        phase_next = PH_CSIGN;
                    end
                    else if (is_digit(st_byte_reg))
                    begin
                        recv_next  = recv_dig;
                        rovf_next  = rovf_reg | recv_sat;
                        phase_next = PH_CDIGITS;
                    end
                    else
                    begin
                        phase_next = PH_CBAD;
                    end
                end
                PH_CSIGN:
                begin
                    if (is_digit(st_byte_reg))
                    begin
                        recv_next  = recv_dig;
                        rovf_next  = rovf_reg | recv_sat;
                        phase_next = PH_CDIGITS;
                    end
                    else
                    begin
                        phase_next = PH_CBAD;
                    end
                end
                PH_CDIGITS:
                begin
                    if (is_digit(st_byte_reg))
                    begin
                        recv_next = recv_dig;
                        rovf_next = rovf_reg | recv_sat;
                    end
                    else
                    begin
                        phase_next = PH_CDONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin : result_logic
        tw_c = (phase_next > PH_CEMPTY) && !fe_next;
        pv_c = tw_c && (phase_next == PH_CDIGITS || phase_next == PH_CDONE)
               && !rovf_next && !rneg_next && (recv_next == {4'd0, sum_next});
        tt_c = '0;
        if (tw_c)
        begin
            tt_c = neg_next ? (TEMP_W'(0) - {1'b0, mag_next}) : {1'b0, mag_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            neg_reg       <= 1'b0;
            cnt_reg       <= '0;
            mag_reg       <= '0;
            sum_reg       <= '0;
            recv_reg      <= '0;
            rneg_reg      <= 1'b0;
            rovf_reg      <= 1'b0;
            fe_reg        <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                st_valid_reg <= in_valid;
            end
            if (st_fire && st_eop_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (st_fire)
            begin
                if (st_eop_reg)
                begin
                    phase_reg <= PH_START;
                    neg_reg   <= 1'b0;
                    cnt_reg   <= '0;
                    mag_reg   <= '0;
                    sum_reg   <= '0;
                    recv_reg  <= '0;
                    rneg_reg  <= 1'b0;
                    rovf_reg  <= 1'b0;
                    fe_reg    <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    cnt_reg   <= cnt_next;
                    mag_reg   <= mag_next;
                    sum_reg   <= sum_next;
                    recv_reg  <= recv_next;
                    rneg_reg  <= rneg_next;
                    rovf_reg  <= rovf_next;
                    fe_reg    <= fe_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            st_byte_reg <= byte_in;
            st_eop_reg  <= end_of_packet;
        end
        if (st_fire && st_eop_reg)
        begin
            pv_reg <= pv_c;
            tw_reg <= tw_c;
            tt_reg <= tt_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packet_valid = pv_reg;
    assign temp_written = tw_reg;
    assign temp_tenths  = $signed(tt_reg);

endmodule
